// ===== rtl/windowed_frequency_admission_filter_unit_defines.svh =====
// assertion macros for the windowed frequency admission filter
// expects clk and rst in the including module's scope
`ifndef WINDOWED_FREQUENCY_ADMISSION_FILTER_UNIT_DEFINES_SVH
`define WINDOWED_FREQUENCY_ADMISSION_FILTER_UNIT_DEFINES_SVH

// same-cycle implication
`define WFAF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WFAF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wfaf_pkg.sv =====
// shared types and constants for the windowed frequency admission filter
// no dependencies
`default_nettype none

package wfaf_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  localparam int KEY_W      = 64;
  localparam int CNT_W      = 16;
  localparam int TIME_W     = 32;
  localparam int LEN_W      = 24;
  localparam int WIN_W      = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_RECORD = 2'd1,
    ACT_ADMIT  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_FREQ  = 2'd0,
    CFG_WINDOW    = 2'd1,
    CFG_MAX_BYTES = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] born_tick;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/wfaf_req_if.sv =====
// request channel: action, query key and response length
// depends on wfaf_pkg
`default_nettype none

interface wfaf_req_if;
  logic                        valid;
  logic                        ready;
  wfaf_pkg::action_t           action;
  logic [wfaf_pkg::KEY_W-1:0]  query_key;
  logic [wfaf_pkg::LEN_W-1:0]  response_bytes;

  modport source (output valid, action, query_key, response_bytes, input ready);
  modport sink   (input valid, action, query_key, response_bytes, output ready);
endinterface

`default_nettype wire

// ===== rtl/wfaf_rsp_if.sv =====
// result channel: admit flag, frequency and table full flag
// depends on wfaf_pkg
`default_nettype none

interface wfaf_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        admit;
  logic [wfaf_pkg::CNT_W-1:0]  frequency;
  logic                        table_full;

  modport source (output valid, admit, frequency, table_full, input ready);
  modport sink   (input valid, admit, frequency, table_full, output ready);
endinterface

`default_nettype wire

// ===== rtl/wfaf_cfg_if.sv =====
// configuration write channel: register index and write data
// depends on wfaf_pkg
`default_nettype none

interface wfaf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wfaf_pkg::CFG_IDX_W-1:0]   index;
  logic [wfaf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/windowed_frequency_admission_filter_unit.sv =====
// windowed frequency admission filter: table of keys with hit counts and ages
// tick: advances the time and goes straight to the finish state, with no sweep
// record, admit, read: one sweep over the table, one entry per cycle through the
// single memory read port and shared age/key compare, then the finish state
// the result is registered once the output is free; requests are taken only in idle
// synchronous reset clears valid bits, time, config to 3 / 3600 / 65536
`default_nettype none

module windowed_frequency_admission_filter_unit (
  input  logic        clk,
  input  logic        rst,
  wfaf_req_if.sink    req,
  wfaf_rsp_if.source  rsp,
  wfaf_cfg_if.sink    cfg
);

  `include "windowed_frequency_admission_filter_unit_defines.svh"

  localparam logic [wfaf_pkg::IDX_W-1:0] LAST_IDX =
    wfaf_pkg::IDX_W'(wfaf_pkg::TABLE_DEPTH - 1);

  // config registers
  logic [wfaf_pkg::CNT_W-1:0]  hit_threshold;
  logic [wfaf_pkg::WIN_W-1:0]  window_ticks;
  logic [wfaf_pkg::LEN_W-1:0]  resp_len_limit;

  // control and request registers
  wfaf_pkg::state_t             state, state_next;
  wfaf_pkg::action_t            op;
  logic [wfaf_pkg::KEY_W-1:0]   key_q;
  logic [wfaf_pkg::LEN_W-1:0]   len_q;
  logic [wfaf_pkg::TIME_W-1:0]  cur_time;

  // sweep registers
  logic [wfaf_pkg::IDX_W-1:0]   rd_idx;
  logic                         issue_done;
  logic                         chk_vld;
  logic [wfaf_pkg::IDX_W-1:0]   chk_idx;
  logic                         found;
  logic [wfaf_pkg::IDX_W-1:0]   found_idx;
  wfaf_pkg::entry_t             found_ent;
  logic                         found_aged;
  logic                         free_found;
  logic [wfaf_pkg::IDX_W-1:0]   free_idx;

  // table
  logic [wfaf_pkg::TABLE_DEPTH-1:0] entry_valid;
  wfaf_pkg::entry_t                 mem [wfaf_pkg::TABLE_DEPTH];
  wfaf_pkg::entry_t                 rd_ent;
  logic                             mem_we;
  logic [wfaf_pkg::IDX_W-1:0]       mem_waddr;
  wfaf_pkg::entry_t                 mem_wdata;

  // result register
  logic                        out_valid;
  logic                        out_admit;
  logic [wfaf_pkg::CNT_W-1:0]  out_freq;
  logic                        out_full;

  // combinational
  logic                        req_go;
  logic                        fin_go;
  logic [wfaf_pkg::TIME_W-1:0] chk_age;
  logic                        chk_aged;
  logic                        chk_live;
  logic                        chk_match;
  logic                        chk_free;
  logic                        chk_last;
  logic [wfaf_pkg::CNT_W-1:0]  cnt_inc;
  logic                        res_admit;
  logic [wfaf_pkg::CNT_W-1:0]  res_freq;
  logic                        res_full;

  assign req.ready = (state == wfaf_pkg::ST_IDLE);
  assign req_go    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid      = out_valid;
  assign rsp.admit      = out_admit;
  assign rsp.frequency  = out_freq;
  assign rsp.table_full = out_full;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_threshold  <= wfaf_pkg::CNT_W'(3);
      window_ticks   <= wfaf_pkg::WIN_W'(3600);
      resp_len_limit <= wfaf_pkg::LEN_W'(65536);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        wfaf_pkg::CFG_MIN_FREQ:  hit_threshold  <= cfg.data[wfaf_pkg::CNT_W-1:0];
        wfaf_pkg::CFG_WINDOW:    window_ticks   <= cfg.data[wfaf_pkg::WIN_W-1:0];
        wfaf_pkg::CFG_MAX_BYTES: resp_len_limit <= cfg.data[wfaf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // shared compare unit on the entry read back this cycle
  always_comb begin
    chk_age   = cur_time - rd_ent.born_tick;
    chk_aged  = chk_age > {1'b0, window_ticks};
    chk_live  = entry_valid[chk_idx] && !((op == wfaf_pkg::ACT_RECORD) && chk_aged);
    chk_match = chk_vld && chk_live && (rd_ent.key == key_q);
    chk_free  = chk_vld && !chk_live;
    chk_last  = chk_vld && (chk_idx == LAST_IDX);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wfaf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    fin_go     = 1'b0;
    unique case (state)
      wfaf_pkg::ST_IDLE: begin
        if (req_go) begin
          state_next = (req.action == wfaf_pkg::ACT_TICK) ? wfaf_pkg::ST_FINISH
                                                          : wfaf_pkg::ST_SWEEP;
        end
      end
      wfaf_pkg::ST_SWEEP: begin
        if (chk_last) begin
          state_next = wfaf_pkg::ST_FINISH;
        end
      end
      wfaf_pkg::ST_FINISH: begin
        if (!out_valid || rsp.ready) begin
          fin_go     = 1'b1;
          state_next = wfaf_pkg::ST_IDLE;
        end
      end
      default: state_next = wfaf_pkg::ST_IDLE;
    endcase
  end

  // result and write-back
  always_comb begin
    cnt_inc   = (found_ent.count == '1) ? found_ent.count
                                        : found_ent.count + wfaf_pkg::CNT_W'(1);
    res_admit = 1'b0;
    res_freq  = '0;
    res_full  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = found ? found_idx : free_idx;
    if (found) begin
      mem_wdata       = found_ent;
      mem_wdata.count = cnt_inc;
    end else begin
      mem_wdata.key       = key_q;
      mem_wdata.count     = wfaf_pkg::CNT_W'(1);
      mem_wdata.born_tick = cur_time;
    end
    unique case (op)
      wfaf_pkg::ACT_TICK: ;
      wfaf_pkg::ACT_RECORD: begin
        mem_we = fin_go && (found || free_found);
        if (found) begin
          res_freq = cnt_inc;
        end else if (free_found) begin
          res_freq = wfaf_pkg::CNT_W'(1);
        end else begin
          res_full = 1'b1;
        end
      end
      wfaf_pkg::ACT_ADMIT: begin
        if (found) begin
          res_freq  = found_ent.count;
          res_admit = (len_q != '0) && (len_q <= resp_len_limit) && !found_aged
                      && (found_ent.count >= hit_threshold);
        end
      end
      wfaf_pkg::ACT_READ: begin
        if (found) begin
          res_freq = found_ent.count;
        end
      end
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      op         <= wfaf_pkg::ACT_TICK;
      cur_time   <= '0;
      issue_done <= 1'b1;
      chk_vld    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      chk_vld <= (state == wfaf_pkg::ST_SWEEP) && !issue_done;
      chk_idx <= rd_idx;
      if (req_go) begin
        op         <= req.action;
        key_q      <= req.query_key;
        len_q      <= req.response_bytes;
        rd_idx     <= '0;
        issue_done <= 1'b0;
        found      <= 1'b0;
        free_found <= 1'b0;
        if (req.action == wfaf_pkg::ACT_TICK) begin
          cur_time <= cur_time + wfaf_pkg::TIME_W'(1);
        end
      end else if ((state == wfaf_pkg::ST_SWEEP) && !issue_done) begin
        rd_idx     <= rd_idx + wfaf_pkg::IDX_W'(1);
        issue_done <= (rd_idx == LAST_IDX);
      end
      if (chk_match && !found) begin
        found      <= 1'b1;
        found_idx  <= chk_idx;
        found_ent  <= rd_ent;
        found_aged <= chk_aged;
      end
      if (chk_free && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= chk_idx;
      end
    end
  end

  // valid bits: expiry during a record sweep, set on insert
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (chk_vld && (op == wfaf_pkg::ACT_RECORD) && entry_valid[chk_idx]
                 && chk_aged) begin
      entry_valid[chk_idx] <= 1'b0;
    end else if (mem_we && !found) begin
      entry_valid[mem_waddr] <= 1'b1;
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_ent <= mem[rd_idx];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (fin_go) begin
      out_admit <= res_admit;
      out_freq  <= res_freq;
      out_full  <= res_full;
    end
  end

  `WFAF_ASSERT_NEXT(a_finish_delivers,
    !rst && (state == wfaf_pkg::ST_FINISH) && (!out_valid || rsp.ready),
    (state == wfaf_pkg::ST_IDLE) && out_valid,
    "finish step did not deliver a result")
  `WFAF_ASSERT_NOW(a_full_clean,
    out_valid && out_full,
    !out_admit && (out_freq == '0),
    "table full result carries admit or frequency")
  `WFAF_ASSERT_NOW(a_admit_count,
    out_valid && out_admit,
    (out_freq != '0) && !out_full,
    "admitted key with zero count")
  `WFAF_ASSERT_NEXT(a_tick_time,
    !rst && req_go && (req.action == wfaf_pkg::ACT_TICK),
    cur_time == $past(cur_time) + wfaf_pkg::TIME_W'(1),
    "tick did not advance time")

endmodule

`default_nettype wire

// ===== dv/wfaf_admission_checker.sv =====
`timescale 1ns / 1ps
// checker for the windowed frequency admission filter: keeps its own table, clock
// and settings, predicts every result and compares it with what the block returns
// depends on wfaf_pkg and the request, result and config interfaces

module wfaf_admission_checker (
  input  logic clk,
  input  logic rst,
  wfaf_req_if  req,
  wfaf_rsp_if  rsp,
  wfaf_cfg_if  cfg,
  output int   mismatches,
  output int   outstanding,
  output int   results_seen,
  output int   admits_seen,
  output int   full_seen
);
  import wfaf_pkg::*;

  localparam int REPORT_CAP = 40;

  typedef struct packed {
    logic             admit;
    logic [CNT_W-1:0] frequency;
    logic             table_full;
  } outcome_t;

  outcome_t pending_outcomes[$];

  bit                slot_used  [TABLE_DEPTH];
  logic [KEY_W-1:0]  slot_key   [TABLE_DEPTH];
  logic [CNT_W-1:0]  slot_hits  [TABLE_DEPTH];
  logic [TIME_W-1:0] slot_born  [TABLE_DEPTH];
  logic [TIME_W-1:0] now_ticks;
  logic [CNT_W-1:0]  min_hits;
  logic [WIN_W-1:0]  window;
  logic [LEN_W-1:0]  len_limit;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
    admits_seen  = 0;
    full_seen    = 0;
  end

  task automatic report(string msg);
    if (mismatches < REPORT_CAP)
      $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic bit stale(int s);
    logic [TIME_W-1:0] age;
    age = now_ticks - slot_born[s];
    return age > {1'b0, window};
  endfunction

  function automatic int lookup(logic [KEY_W-1:0] k);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (slot_used[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic outcome_t admission_outcome(action_t act, logic [KEY_W-1:0] k,
                                                 logic [LEN_W-1:0] len);
    outcome_t o;
    int       s;
    int       f;
    o = '0;
    case (act)
      ACT_TICK: now_ticks = now_ticks + TIME_W'(1);
      ACT_RECORD: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (slot_used[i] && stale(i)) slot_used[i] = 1'b0;
        s = lookup(k);
        if (s >= 0) begin
          if (slot_hits[s] != '1) slot_hits[s] = slot_hits[s] + CNT_W'(1);
          o.frequency = slot_hits[s];
        end else begin
          f = -1;
          for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            if (!slot_used[i]) f = i;
          if (f >= 0) begin
            slot_used[f] = 1'b1;
            slot_key[f]  = k;
            slot_hits[f] = CNT_W'(1);
            slot_born[f] = now_ticks;
            o.frequency  = CNT_W'(1);
          end else begin
            o.table_full = 1'b1;
          end
        end
      end
      ACT_ADMIT: begin
        s = lookup(k);
        if (s >= 0) begin
          o.frequency = slot_hits[s];
          o.admit = (len != 0) && (len <= len_limit) && !stale(s) &&
                    (slot_hits[s] >= min_hits);
        end
      end
      default: begin
        s = lookup(k);
        if (s >= 0) o.frequency = slot_hits[s];
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    outcome_t got;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
      now_ticks = '0;
      min_hits  = 16'd3;
      window    = 31'd3600;
      len_limit = 24'd65536;
      pending_outcomes.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_MIN_FREQ:  min_hits  = cfg.data[CNT_W-1:0];
          CFG_WINDOW:    window    = cfg.data[WIN_W-1:0];
          CFG_MAX_BYTES: len_limit = cfg.data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        got = '{admit: rsp.admit, frequency: rsp.frequency, table_full: rsp.table_full};
        results_seen++;
        if (got.admit) admits_seen++;
        if (got.table_full) full_seen++;
        if (pending_outcomes.size() == 0) begin
          report($sformatf("result with nothing pending: admit %0b freq %0d full %0b",
                           got.admit, got.frequency, got.table_full));
        end else begin
          want = pending_outcomes.pop_front();
          if (got.admit !== want.admit)
            report($sformatf("result %0d admit: got %b expected %b",
                             results_seen, got.admit, want.admit));
          if (got.frequency !== want.frequency)
            report($sformatf("result %0d frequency: got %0d expected %0d",
                             results_seen, got.frequency, want.frequency));
          if (got.table_full !== want.table_full)
            report($sformatf("result %0d table_full: got %b expected %b",
                             results_seen, got.table_full, want.table_full));
        end
      end
      if (req.valid && req.ready)
        pending_outcomes.push_back(admission_outcome(req.action, req.query_key,
                                                     req.response_bytes));
    end
    outstanding = pending_outcomes.size();
  end

endmodule

// ===== dv/windowed_frequency_admission_filter_unit_test.sv =====
`timescale 1ns / 1ps
// top of the admission filter bench: clock, reset, request and config stimulus,
// result-side stalls and the verdict; depends on wfaf_pkg, the interfaces,
// the block and wfaf_admission_checker

module windowed_frequency_admission_filter_unit_test;
  import wfaf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int LONG_HOLD = 3000;
  localparam int POOL_MAX  = 16;

  logic clk;
  logic rst;

  wfaf_req_if req_ch ();
  wfaf_rsp_if rsp_ch ();
  wfaf_cfg_if cfg_ch ();

  int mismatches;
  int outstanding;
  int results_seen;
  int admits_seen;
  int full_seen;

  int requests_sent;
  int hold_requests;
  int holds_done;
  bit idle_en;
  int pool_size;
  logic [LEN_W-1:0] cur_max_bytes;
  logic [KEY_W-1:0] key_pool [POOL_MAX];

  windowed_frequency_admission_filter_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  wfaf_admission_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg          (cfg_ch),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .admits_seen  (admits_seen),
    .full_seen    (full_seen)
  );

  always #6 clk = ~clk;

  // result side: long hold-offs on request, random stall bursts otherwise while idle_en is set
  initial begin
    rsp_ch.ready = 1'b0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        rsp_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  initial begin
    #40_000_000;
    $display("windowed_frequency_admission_filter_unit_test: errors");
    $finish;
  end

  function automatic logic [KEY_W-1:0] fresh_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    return LEN_W'($urandom);
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return cur_max_bytes;
      2: return cur_max_bytes + LEN_W'(1);
      3: return '1;
      4: return LEN_W'(1);
      default: return LEN_W'($urandom_range(1, (cur_max_bytes == 0) ? 1 : cur_max_bytes));
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return fresh_key();
    return key_pool[$urandom_range(0, pool_size - 1)];
  endfunction

  task automatic refill_pool(int n);
    pool_size = n;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_MAX; i++) key_pool[i] = fresh_key();
  endtask

  task automatic send(action_t act, logic [KEY_W-1:0] k, logic [LEN_W-1:0] len);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    req_ch.valid          = 1'b1;
    req_ch.action         = act;
    req_ch.query_key      = k;
    req_ch.response_bytes = len;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic drain();
    req_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // upper bits beyond the register width carry junk on purpose
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value,
                           logic [CFG_DATA_W-1:0] junk);
    drain();
    if (idx == CFG_MAX_BYTES) cur_max_bytes = value[LEN_W-1:0];
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value | junk;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic run_mix(int n, int tick_pct, int rec_pct, int adm_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < tick_pct)
        send(ACT_TICK, fresh_key(), rand_len());
      else if (r < tick_pct + rec_pct)
        send(ACT_RECORD, pick_key(), rand_len());
      else if (r < tick_pct + rec_pct + adm_pct)
        send(ACT_ADMIT, pick_key(), pick_len());
      else
        send(ACT_READ, pick_key(), rand_len());
    end
  endtask

  // mostly new keys so the table runs out of slots
  task automatic run_fill(int n);
    int r;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        k = fresh_key();
        if (r < 5) key_pool[$urandom_range(2, POOL_MAX - 1)] = k;
        send(ACT_RECORD, k, rand_len());
      end else if (r < 80) begin
        send(ACT_RECORD, pick_key(), rand_len());
      end else if (r < 92) begin
        send(ACT_ADMIT, pick_key(), pick_len());
      end else if (r < 97) begin
        send(ACT_READ, pick_key(), rand_len());
      end else begin
        send(ACT_TICK, fresh_key(), rand_len());
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_TICK;
    req_ch.query_key = '0;
    req_ch.response_bytes = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MIN_FREQ;
    cfg_ch.data = '0;
    requests_sent = 0;
    hold_requests = 0;
    idle_en = 1'b1;
    cur_max_bytes = 24'd65536;
    refill_pool(8);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: absent keys, threshold, length limits, extreme keys
    send(ACT_READ, '0, '0);
    send(ACT_ADMIT, '0, LEN_W'(1));
    repeat (3) send(ACT_RECORD, '0, rand_len());
    send(ACT_ADMIT, '0, cur_max_bytes);
    send(ACT_ADMIT, '0, cur_max_bytes + LEN_W'(1));
    send(ACT_ADMIT, '0, '0);
    send(ACT_ADMIT, '0, LEN_W'(1));
    send(ACT_ADMIT, '0, '1);
    send(ACT_RECORD, '1, '1);
    send(ACT_READ, '1, '0);
    send(ACT_ADMIT, '1, LEN_W'(1));
    send(ACT_TICK, '1, '1);
    send(ACT_READ, '0, '1);
    cfg_write(CFG_MIN_FREQ, 32'd1, 32'h0);
    cfg_write(CFG_UNUSED, 32'hFFFF_FFFF, 32'h0);
    send(ACT_ADMIT, '1, LEN_W'(1));
    send(ACT_RECORD, '1, '0);
    cfg_write(CFG_MIN_FREQ, 32'd3, 32'h0);

    // reset settings, small key pool, with one long result-side hold-off
    run_mix(100, 20, 35, 30);
    hold_requests++;
    run_mix(100, 20, 35, 30);

    // short window so entries age out between ticks
    refill_pool(10);
    cfg_write(CFG_MIN_FREQ, 32'd1, 32'hABCD_0000);
    cfg_write(CFG_WINDOW, 32'd5, 32'h8000_0000);
    cfg_write(CFG_MAX_BYTES, 32'd100, 32'h5A00_0000);
    run_mix(125, 40, 30, 20);
    drain();
    run_mix(125, 40, 30, 20);

    // zero threshold, zero window, zero length limit
    cfg_write(CFG_MIN_FREQ, 32'd0, 32'h0);
    cfg_write(CFG_WINDOW, 32'd0, 32'h0);
    cfg_write(CFG_MAX_BYTES, 32'd0, 32'h0);
    run_mix(100, 30, 35, 25);

    // widest window and length limit, table driven to full
    refill_pool(POOL_MAX);
    cfg_write(CFG_MIN_FREQ, 32'd2, 32'h0);
    cfg_write(CFG_WINDOW, 32'h7FFF_FFFF, 32'h8000_0000);
    cfg_write(CFG_MAX_BYTES, 32'hFF_FFFF, 32'hFF00_0000);
    run_fill(330);

    // zero window plus a tick flushes the whole table on the next record
    cfg_write(CFG_WINDOW, 32'd0, 32'h0);
    send(ACT_TICK, fresh_key(), rand_len());
    send(ACT_RECORD, key_pool[2], rand_len());
    refill_pool(8);
    cfg_write(CFG_MIN_FREQ, 32'hFFFF, 32'h0);
    cfg_write(CFG_WINDOW, $urandom_range(1, 50), 32'h0);
    cfg_write(CFG_MAX_BYTES, $urandom_range(1, 24'hFF_FFFF), 32'h0);
    run_mix(60, 30, 35, 25);
    cfg_write(CFG_MIN_FREQ, $urandom_range(1, 4), 32'h0);
    idle_en = 1'b0;
    run_mix(90, 25, 40, 25);

    drain();
    repeat (TABLE_DEPTH + 8) @(negedge clk);
    $display("covered %0d requests and %0d checked results over several settings",
             requests_sent, results_seen);
    $display("including %0d admissions and %0d table-full answers", admits_seen, full_seen);
    if (mismatches == 0) begin
      $display("windowed_frequency_admission_filter_unit_test: clean");
    end else begin
      $display("windowed_frequency_admission_filter_unit_test: errors");
    end
    $finish;
  end

endmodule

// ===== windowed_frequency_admission_filter_unit.f =====
+incdir+rtl
rtl/wfaf_pkg.sv
rtl/wfaf_req_if.sv
rtl/wfaf_rsp_if.sv
rtl/wfaf_cfg_if.sv
rtl/windowed_frequency_admission_filter_unit.sv
dv/wfaf_admission_checker.sv
dv/windowed_frequency_admission_filter_unit_test.sv
